### rtl/lfs_pkg.sv
// Package for the two-wire LED driver frame sender.
// Holds word types, command constants, register indexes and the phase enum.
// No dependencies.
`timescale 1ns / 1ps

package lfs_pkg;

	localparam int MAX_DIGITS = 6;
	localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_ON  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS  = 2'd2;

	localparam logic [7:0] CMD_DATA = 8'b0100_0000;
	localparam logic [7:0] CMD_DISP = 8'b1000_0000;
	localparam logic [7:0] CMD_ADDR = 8'b1100_0000;

	localparam logic [2:0] LAST_BIT     = 3'd7;
	localparam logic [1:0] FRAME_DATA   = 2'd0;
	localparam logic [1:0] FRAME_ADDR   = 2'd1;
	localparam logic [1:0] FRAME_DISP   = 2'd2;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_BEGIN = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_LEAD     = 4'd1,
		PH_START_A  = 4'd2,
		PH_START_B  = 4'd3,
		PH_BIT_LOW  = 4'd4,
		PH_BIT_HIGH = 4'd5,
		PH_ACK_WAIT = 4'd6,
		PH_ACK_HIGH = 4'd7,
		PH_STOP_A   = 4'd8,
		PH_STOP_B   = 4'd9,
		PH_STOP_C   = 4'd10
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] digit_index;
		logic [7:0] digit_value;
		logic       ack_in;
	} in_word_t;

	typedef struct packed {
		logic clk_level;
		logic dio_level;
		logic busy_res;
		logic done_res;
	} out_word_t;

endpackage

### rtl/led_driver_two_wire_frame_sender.sv
// Top level of the two-wire LED driver frame sender: input register, phase
// sequencer with digit store, and result register. Depends on lfs_pkg.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+-----------------------------------
//  in       | in        | in_valid / in_stall | func, digit_index, digit_value, ack
//  out      | out       | out_valid/out_stall | clk_level, dio_level, busy, done
//  cfg      | in        | cfg_wr              | cfg_index, cfg_data
//
//  One word is accepted every clock while in_stall is low; its result passes
//  through the input register and then the result register.
//  The sequencer state advances in the cycle the input register hands over.
//  A stalled result holds the result register and, through it, the input
//  register; new words wait on in_stall.
//  Reset clears the sequencer, the digit store and both valid flags.

module led_driver_two_wire_frame_sender (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  lfs_pkg::in_word_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output lfs_pkg::out_word_t               out_data,
	input  logic                             cfg_wr,
	input  logic [lfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import lfs_pkg::*;

	logic       valid_s1;
	in_word_t   word_s1;
	logic       out_valid_q;
	out_word_t  out_q;
	logic       advance;

	logic [2:0] digit_count_q;
	logic       display_on_q;
	logic [2:0] brightness_q;

	phase_t            phase_q, phase_d;
	logic [1:0]        frame_q, frame_d;
	logic [2:0]        bit_q, bit_d;
	logic [CNT_W-1:0]  bytepos_q, bytepos_d;
	logic [7:0]        shift_q, shift_d;
	logic              clk_pin_q, clk_pin_d;
	logic              dio_pin_q, dio_pin_d;
	logic              done_d;
	logic [7:0]        digits_q [MAX_DIGITS];
	logic [7:0]        command;
	logic [CNT_W-1:0]  eff_count;
	logic              more_digits;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= 3'd4;
			display_on_q  <= 1'b1;
			brightness_q  <= 3'd7;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_DIGIT_COUNT: digit_count_q <= cfg_data;
				CFG_DISPLAY_ON:  display_on_q  <= cfg_data[0];
				CFG_BRIGHTNESS:  brightness_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_data;
		end
	end

	always_comb begin
		case (frame_q)
			FRAME_DATA: command = CMD_DATA;
			FRAME_ADDR: command = CMD_ADDR;
			default:    command = CMD_DISP | {4'b0, display_on_q, brightness_q};
		endcase
		if (int'(digit_count_q) > MAX_DIGITS) begin
			eff_count = CNT_W'(MAX_DIGITS);
		end else begin
			eff_count = CNT_W'(digit_count_q);
		end
		more_digits = (frame_q == FRAME_ADDR) && (bytepos_q < eff_count)
			&& (int'(bytepos_q) < MAX_DIGITS);
	end

	always_comb begin
		phase_d   = phase_q;
		frame_d   = frame_q;
		bit_d     = bit_q;
		bytepos_d = bytepos_q;
		shift_d   = shift_q;
		clk_pin_d = clk_pin_q;
		dio_pin_d = dio_pin_q;
		done_d    = 1'b0;
		case (func_t'(word_s1.func))
			FUNC_TICK: begin
				case (phase_q)
					PH_IDLE: ;
					PH_LEAD: begin
						clk_pin_d = 1'b1;
						dio_pin_d = 1'b1;
						phase_d   = PH_START_A;
					end
					PH_START_A: begin
						clk_pin_d = 1'b1;
						dio_pin_d = 1'b1;
						phase_d   = PH_START_B;
					end
					PH_START_B: begin
						clk_pin_d = 1'b1;
						dio_pin_d = 1'b0;
						shift_d   = command;
						bit_d     = 3'd0;
						phase_d   = PH_BIT_LOW;
					end
					PH_BIT_LOW: begin
						clk_pin_d = 1'b0;
						dio_pin_d = shift_q[0];
						phase_d   = PH_BIT_HIGH;
					end
					PH_BIT_HIGH: begin
						clk_pin_d = 1'b1;
						shift_d   = {1'b0, shift_q[7:1]};
						if (bit_q == LAST_BIT) begin
							bit_d   = 3'd0;
							phase_d = PH_ACK_WAIT;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = PH_BIT_LOW;
						end
					end
					PH_ACK_WAIT: begin
						clk_pin_d = 1'b0;
						dio_pin_d = 1'b1;
						if (!word_s1.ack_in) begin
							phase_d = PH_ACK_HIGH;
						end
					end
					PH_ACK_HIGH: begin
						clk_pin_d = 1'b1;
						dio_pin_d = 1'b1;
						if (more_digits) begin
							shift_d   = digits_q[IDX_W'(bytepos_q)];
							bytepos_d = bytepos_q + CNT_W'(1);
							bit_d     = 3'd0;
							phase_d   = PH_BIT_LOW;
						end else begin
							phase_d = PH_STOP_A;
						end
					end
					PH_STOP_A: begin
						clk_pin_d = 1'b0;
						dio_pin_d = 1'b0;
						phase_d   = PH_STOP_B;
					end
					PH_STOP_B: begin
						clk_pin_d = 1'b1;
						dio_pin_d = 1'b0;
						phase_d   = PH_STOP_C;
					end
					PH_STOP_C: begin
						clk_pin_d = 1'b1;
						dio_pin_d = 1'b1;
						if (frame_q >= FRAME_DISP) begin
							frame_d = FRAME_DATA;
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end else begin
							frame_d = frame_q + 2'd1;
							phase_d = PH_START_A;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
			FUNC_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					phase_d   = PH_LEAD;
					frame_d   = FRAME_DATA;
					bytepos_d = '0;
					bit_d     = 3'd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			frame_q   <= FRAME_DATA;
			bit_q     <= 3'd0;
			bytepos_q <= '0;
			shift_q   <= 8'd0;
			clk_pin_q <= 1'b1;
			dio_pin_q <= 1'b1;
		end else if (valid_s1 && advance) begin
			phase_q   <= phase_d;
			frame_q   <= frame_d;
			bit_q     <= bit_d;
			bytepos_q <= bytepos_d;
			shift_q   <= shift_d;
			clk_pin_q <= clk_pin_d;
			dio_pin_q <= dio_pin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digits_q[i] <= 8'd0;
			end
		end else if (valid_s1 && advance && func_t'(word_s1.func) == FUNC_LOAD
			&& int'(word_s1.digit_index) < MAX_DIGITS) begin
			digits_q[IDX_W'(word_s1.digit_index)] <= word_s1.digit_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.clk_level <= clk_pin_d;
			out_q.dio_level <= dio_pin_d;
			out_q.busy_res  <= (phase_d != PH_IDLE);
			out_q.done_res  <= done_d;
		end
	end

	a_idle_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && func_t'(word_s1.func) == FUNC_TICK && phase_q == PH_IDLE)
		|=> (phase_q == PH_IDLE))
		else $error("tick while idle moved the sequencer");

	a_bytepos_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(bytepos_q) <= MAX_DIGITS)
		else $error("byte position beyond digit store");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q != 2'd3)
		else $error("frame number out of range");

	a_done_released: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done_res)
		|-> (out_q.clk_level && out_q.dio_level && !out_q.busy_res))
		else $error("done without both pins released and idle");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && done_d) |=> (phase_q == PH_IDLE && frame_q == FRAME_DATA))
		else $error("final stop did not return to idle");

endmodule
